// File: sv/rvs_pkg.sv
// Shared constants and types for the recognition vote stabiliser.
`timescale 1ns / 1ps

package rvs_pkg;

    localparam int MAX_OBJECTS = 16;

    localparam int CNT_W   = 16;
    localparam int IDX_W   = 5;
    localparam int CFG_IDX_W = 2;

    localparam logic [CNT_W-1:0] CNT_MAX = {CNT_W{1'b1}};

    localparam logic [CNT_W-1:0] OBJ_HIT_GAIN  = 16'd2;
    localparam logic [CNT_W-1:0] OBJ_MISS_LOSS = 16'd1;
    localparam logic [CNT_W-1:0] NOOBJ_GAIN    = 16'd1;
    localparam logic [CNT_W-1:0] NOOBJ_LOSS    = 16'd3;

    localparam logic [CNT_W-1:0] CERT_LIMIT_RST = 16'd17039;
    localparam logic [CNT_W-1:0] VOTE_LIMIT_RST = 16'd10;
    localparam logic [IDX_W-1:0] OBJ_COUNT_RST  = 5'd0;
    localparam logic [CNT_W-1:0] STEP_LIMIT_RST = 16'd300;

    localparam logic [CFG_IDX_W-1:0] CFG_CERT_LIMIT = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_VOTE_LIMIT = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_OBJ_COUNT  = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_STEP_LIMIT = 2'd3;

    typedef struct packed {
        logic clear;
        logic apply;
        logic hit;
    } lane_cmd_t;

endpackage

// File: sv/rvs_vote_lane.sv
// One vote counter with its saturating update.
`timescale 1ns / 1ps

module rvs_vote_lane (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         en,
    input  rvs_pkg::lane_cmd_t           cmd,
    input  logic                         is_object,
    input  logic                         is_nobj,
    input  logic                         is_match,
    output logic [rvs_pkg::CNT_W-1:0]    cnt_new
);

    logic [rvs_pkg::CNT_W-1:0] cnt_reg;
    logic [rvs_pkg::CNT_W-1:0] base;
    logic [rvs_pkg::CNT_W-1:0] gain;
    logic [rvs_pkg::CNT_W-1:0] loss;
    logic [rvs_pkg::CNT_W:0]   sum;
    logic                      grow;

    always_comb
    begin
        base = cmd.clear ? '0 : cnt_reg;
        grow = 1'b0;
        gain = '0;
        loss = '0;
        if (is_object)
        begin
            grow = cmd.hit && is_match;
            gain = rvs_pkg::OBJ_HIT_GAIN;
            loss = rvs_pkg::OBJ_MISS_LOSS;
        end
        else if (is_nobj)
        begin
            grow = !cmd.hit;
            gain = rvs_pkg::NOOBJ_GAIN;
            loss = rvs_pkg::NOOBJ_LOSS;
        end
        sum = {1'b0, base} + {1'b0, gain};
        cnt_new = base;
        if (cmd.apply && (is_object || is_nobj))
        begin
            if (grow)
                cnt_new = sum[rvs_pkg::CNT_W] ? rvs_pkg::CNT_MAX : sum[rvs_pkg::CNT_W-1:0];
            else
                cnt_new = (base > loss) ? (base - loss) : '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            cnt_reg <= '0;
        else if (en)
            cnt_reg <= cnt_new;
    end

endmodule

// File: sv/rvs_argmax.sv
// Comparator tree returning the first largest counter among the eligible ones.
`timescale 1ns / 1ps

module rvs_argmax #(
    parameter int N  = rvs_pkg::MAX_OBJECTS + 1,
    parameter int IW = rvs_pkg::IDX_W
) (
    input  logic [N-1:0][rvs_pkg::CNT_W-1:0] vals,
    input  logic [IW-1:0]                    last_idx,
    output logic [rvs_pkg::CNT_W-1:0]        best_val,
    output logic [IW-1:0]                    best_idx
);

    localparam int LVL = (N > 1) ? $clog2(N) : 1;
    localparam int P   = 1 << LVL;

    logic                      node_vld [2*P-1];
    logic [rvs_pkg::CNT_W-1:0] node_val [2*P-1];
    logic [IW-1:0]             node_idx [2*P-1];

    genvar k;
    generate
        for (k = 0; k < P; k++)
        begin : g_leaf
            if (k < N)
            begin : g_used
                assign node_vld[P-1+k] = (IW'(k) <= last_idx);
                assign node_val[P-1+k] = vals[k];
                assign node_idx[P-1+k] = IW'(k);
            end
            else
            begin : g_pad
                assign node_vld[P-1+k] = 1'b0;
                assign node_val[P-1+k] = '0;
                assign node_idx[P-1+k] = '0;
            end
        end
        for (k = 0; k < P-1; k++)
        begin : g_node
            logic take_right;
            assign take_right = node_vld[2*k+2] &&
                                (!node_vld[2*k+1] || (node_val[2*k+2] > node_val[2*k+1]));
            assign node_vld[k] = node_vld[2*k+1] || node_vld[2*k+2];
            assign node_val[k] = take_right ? node_val[2*k+2] : node_val[2*k+1];
            assign node_idx[k] = take_right ? node_idx[2*k+2] : node_idx[2*k+1];
        end
    endgenerate

    assign best_val = node_val[0];
    assign best_idx = node_idx[0];

endmodule

// File: sv/recognition_vote_stabilizer_core.sv
// Top level of the recognition vote stabiliser.
//
//   channel   direction  handshake              payload
//   input     in         in_valid / in_stall    start_req has_frame certainty match_index
//   result    out        out_valid / out_stall  done_res recognized winner_index timed_out
//   config    in         cfg_we                 cfg_index cfg_data
//
// One transaction is taken per cycle while in_stall is low; its result is registered when it is processed.
// The counter update and comparator tree sit between the input and result registers.
// Reset clears counters, session and step count and loads the register defaults.
// A stalled result holds; the input register takes one more transaction, then in_stall rises.
`timescale 1ns / 1ps

module recognition_vote_stabilizer_core #(
    parameter int MAX_OBJECTS = rvs_pkg::MAX_OBJECTS
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             in_valid,
    output logic                             in_stall,
    input  logic                             start_req,
    input  logic                             has_frame,
    input  logic [rvs_pkg::CNT_W-1:0]        certainty,
    input  logic [rvs_pkg::IDX_W-1:0]        match_index,
    output logic                             out_valid,
    input  logic                             out_stall,
    output logic                             done_res,
    output logic                             recognized,
    output logic [rvs_pkg::IDX_W-1:0]        winner_index,
    output logic                             timed_out,
    input  logic                             cfg_we,
    input  logic [rvs_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [rvs_pkg::CNT_W-1:0]        cfg_data
);

    localparam int N  = MAX_OBJECTS + 1;
    localparam int IW = ($clog2(N) > rvs_pkg::IDX_W) ? $clog2(N) : rvs_pkg::IDX_W;

    logic [rvs_pkg::CNT_W-1:0] cert_limit_reg;
    logic [rvs_pkg::CNT_W-1:0] vote_limit_reg;
    logic [rvs_pkg::IDX_W-1:0] obj_count_reg;
    logic [rvs_pkg::CNT_W-1:0] step_limit_reg;

    logic                      in_valid_reg;
    logic                      start_reg;
    logic                      frame_reg;
    logic [rvs_pkg::CNT_W-1:0] cert_reg;
    logic [rvs_pkg::IDX_W-1:0] match_reg;

    logic                      active_reg;
    logic                      active_next;
    logic [rvs_pkg::CNT_W-1:0] step_reg;
    logic [rvs_pkg::CNT_W-1:0] step_next;

    logic                      res_valid_reg;
    logic                      done_reg;
    logic                      done_next;
    logic                      rec_reg;
    logic                      rec_next;
    logic [rvs_pkg::IDX_W-1:0] win_reg;
    logic [rvs_pkg::IDX_W-1:0] win_next;
    logic                      tout_reg;
    logic                      tout_next;

    logic                      proc_fire;
    logic                      active_eff;
    logic [IW-1:0]             n_ext;
    rvs_pkg::lane_cmd_t        cmd;
    logic [N-1:0][rvs_pkg::CNT_W-1:0] cnt_new_all;
    logic [rvs_pkg::CNT_W-1:0] best_val;
    logic [IW-1:0]             best_idx;
    logic [rvs_pkg::CNT_W-1:0] step_base;
    logic [rvs_pkg::CNT_W-1:0] step_inc;

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cert_limit_reg <= rvs_pkg::CERT_LIMIT_RST;
            vote_limit_reg <= rvs_pkg::VOTE_LIMIT_RST;
            obj_count_reg  <= rvs_pkg::OBJ_COUNT_RST;
            step_limit_reg <= rvs_pkg::STEP_LIMIT_RST;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                rvs_pkg::CFG_CERT_LIMIT: cert_limit_reg <= cfg_data;
                rvs_pkg::CFG_VOTE_LIMIT: vote_limit_reg <= cfg_data;
                rvs_pkg::CFG_OBJ_COUNT:  obj_count_reg  <= cfg_data[rvs_pkg::IDX_W-1:0];
                rvs_pkg::CFG_STEP_LIMIT: step_limit_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    // Handshake
    assign proc_fire = in_valid_reg && (!res_valid_reg || !out_stall);
    assign in_stall  = in_valid_reg && !proc_fire;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid_reg <= 1'b0;
        else if (!in_stall)
            in_valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && !in_stall)
        begin
            start_reg <= start_req;
            frame_reg <= has_frame;
            cert_reg  <= certainty;
            match_reg <= match_index;
        end
    end

    // Counter lanes
    assign n_ext = (IW'(obj_count_reg) > IW'(MAX_OBJECTS)) ? IW'(MAX_OBJECTS)
                                                           : IW'(obj_count_reg);
    assign active_eff = start_reg || active_reg;
    assign cmd.clear  = start_reg;
    assign cmd.apply  = active_eff && frame_reg;
    assign cmd.hit    = (cert_reg >= cert_limit_reg);

    genvar i;
    generate
        for (i = 0; i < N; i++)
        begin : g_lane
            rvs_vote_lane u_lane (
                .clk       (clk),
                .rst_n     (rst_n),
                .en        (proc_fire),
                .cmd       (cmd),
                .is_object (IW'(i) < n_ext),
                .is_nobj   (IW'(i) == n_ext),
                .is_match  (IW'(i) == IW'(match_reg)),
                .cnt_new   (cnt_new_all[i])
            );
        end
    endgenerate

    rvs_argmax #(
        .N  (N),
        .IW (IW)
    ) u_argmax (
        .vals     (cnt_new_all),
        .last_idx (n_ext),
        .best_val (best_val),
        .best_idx (best_idx)
    );

    // Decision and step limit
    assign step_base = start_reg ? '0 : step_reg;
    assign step_inc  = (step_base == rvs_pkg::CNT_MAX) ? step_base : step_base + 1'b1;

    always_comb
    begin
        active_next = active_reg;
        step_next   = step_reg;
        done_next   = 1'b0;
        rec_next    = 1'b0;
        win_next    = '0;
        tout_next   = 1'b0;
        if (active_eff)
        begin
            active_next = 1'b1;
            if (best_val > vote_limit_reg)
            begin
                step_next   = step_base;
                active_next = 1'b0;
                done_next   = 1'b1;
                rec_next    = (best_idx < n_ext);
                win_next    = best_idx[rvs_pkg::IDX_W-1:0];
            end
            else
            begin
                step_next = step_inc;
                if (step_inc > step_limit_reg)
                begin
                    active_next = 1'b0;
                    done_next   = 1'b1;
                    win_next    = n_ext[rvs_pkg::IDX_W-1:0];
                    tout_next   = 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg    <= 1'b0;
            step_reg      <= '0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            if (proc_fire)
            begin
                active_reg <= active_next;
                step_reg   <= step_next;
            end
            if (proc_fire)
                res_valid_reg <= 1'b1;
            else if (!out_stall)
                res_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (proc_fire)
        begin
            done_reg <= done_next;
            rec_reg  <= rec_next;
            win_reg  <= win_next;
            tout_reg <= tout_next;
        end
    end

    assign out_valid    = res_valid_reg;
    assign done_res     = done_reg;
    assign recognized   = rec_reg;
    assign winner_index = win_reg;
    assign timed_out    = tout_reg;

    a_fire_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
        proc_fire |=> res_valid_reg)
        else $error("processed transaction left no result");

    a_done_ends_session: assert property (@(posedge clk) disable iff (!rst_n)
        proc_fire && done_next |=> !active_reg)
        else $error("session still active after completion");

    a_recognised_is_done: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid_reg && rec_reg |-> done_reg && !tout_reg)
        else $error("recognition flagged without a decision");

    a_idle_no_change: assert property (@(posedge clk) disable iff (!rst_n)
        proc_fire && !active_eff |=> $stable(step_reg) && !active_reg)
        else $error("idle transaction altered session state");

endmodule

// File: tb/tb_recognition_vote_stabilizer_core.sv
// Self-checking testbench for the recognition vote stabiliser core.
`timescale 1ns / 1ps

module tb_recognition_vote_stabilizer_core;

    localparam int QUIET_LIMIT = 2000;

    typedef struct packed {
        logic                     start_req;
        logic                     has_frame;
        logic [rvs_pkg::CNT_W-1:0] certainty;
        logic [rvs_pkg::IDX_W-1:0] match_index;
    } poll_t;

    typedef struct packed {
        logic                     done_res;
        logic                     recognized;
        logic [rvs_pkg::IDX_W-1:0] winner_index;
        logic                     timed_out;
    } verdict_t;

    class verdict_board;
        logic [rvs_pkg::CNT_W-1:0]     votes [rvs_pkg::MAX_OBJECTS+1];
        logic                         active;
        logic [rvs_pkg::CNT_W-1:0]     steps;
        logic [rvs_pkg::CNT_W-1:0]     cert_limit;
        logic [rvs_pkg::CNT_W-1:0]     vote_limit;
        logic [rvs_pkg::IDX_W-1:0]     obj_count;
        logic [rvs_pkg::CNT_W-1:0]     step_limit;
        verdict_t                     due [$];
        int                           errors;

        function new();
            foreach (votes[i])
                votes[i] = '0;
            active     = 1'b0;
            steps      = '0;
            cert_limit = rvs_pkg::CERT_LIMIT_RST;
            vote_limit = rvs_pkg::VOTE_LIMIT_RST;
            obj_count  = rvs_pkg::OBJ_COUNT_RST;
            step_limit = rvs_pkg::STEP_LIMIT_RST;
            errors     = 0;
        endfunction

        function void write_reg(logic [rvs_pkg::CFG_IDX_W-1:0] idx,
                                logic [rvs_pkg::CNT_W-1:0] data);
            case (idx)
                rvs_pkg::CFG_CERT_LIMIT: cert_limit = data;
                rvs_pkg::CFG_VOTE_LIMIT: vote_limit = data;
                rvs_pkg::CFG_OBJ_COUNT:  obj_count  = data[rvs_pkg::IDX_W-1:0];
                rvs_pkg::CFG_STEP_LIMIT: step_limit = data;
                default: ;
            endcase
        endfunction

        function int used_objects();
            return (obj_count > rvs_pkg::MAX_OBJECTS) ? rvs_pkg::MAX_OBJECTS
                                                      : int'(obj_count);
        endfunction

        function logic [rvs_pkg::CNT_W-1:0] raise(logic [rvs_pkg::CNT_W-1:0] v,
                                                  logic [rvs_pkg::CNT_W-1:0] d);
            logic [rvs_pkg::CNT_W:0] s;
            s = v + d;
            return (s > rvs_pkg::CNT_MAX) ? rvs_pkg::CNT_MAX : s[rvs_pkg::CNT_W-1:0];
        endfunction

        function logic [rvs_pkg::CNT_W-1:0] lower(logic [rvs_pkg::CNT_W-1:0] v,
                                                  logic [rvs_pkg::CNT_W-1:0] d);
            return (v > d) ? v - d : '0;
        endfunction

        function verdict_t predict_verdict(poll_t p);
            verdict_t                 v;
            int                       n;
            int                       best_idx;
            logic [rvs_pkg::CNT_W-1:0] best;
            logic                     hit;
            v = '0;
            n = used_objects();
            if (p.start_req)
            begin
                foreach (votes[i])
                    votes[i] = '0;
                steps  = '0;
                active = 1'b1;
            end
            if (!active)
                return v;
            if (p.has_frame)
            begin
                hit = (p.certainty >= cert_limit);
                for (int i = 0; i < n; i++)
                begin
                    if (hit && i == p.match_index)
                        votes[i] = raise(votes[i], rvs_pkg::OBJ_HIT_GAIN);
                    else
                        votes[i] = lower(votes[i], rvs_pkg::OBJ_MISS_LOSS);
                end
                votes[n] = hit ? lower(votes[n], rvs_pkg::NOOBJ_LOSS)
                               : raise(votes[n], rvs_pkg::NOOBJ_GAIN);
            end
            best     = votes[0];
            best_idx = 0;
            for (int i = 1; i <= n; i++)
            begin
                if (votes[i] > best)
                begin
                    best     = votes[i];
                    best_idx = i;
                end
            end
            if (best > vote_limit)
            begin
                active         = 1'b0;
                v.done_res     = 1'b1;
                v.recognized   = (best_idx < n);
                v.winner_index = best_idx[rvs_pkg::IDX_W-1:0];
                return v;
            end
            if (steps != rvs_pkg::CNT_MAX)
                steps++;
            if (steps > step_limit)
            begin
                active         = 1'b0;
                v.done_res     = 1'b1;
                v.winner_index = n[rvs_pkg::IDX_W-1:0];
                v.timed_out    = 1'b1;
            end
            return v;
        endfunction

        function void note_poll(poll_t p);
            due = {due, predict_verdict(p)};
        endfunction

        function void check_verdict(verdict_t got);
            verdict_t want;
            if (due.size() == 0)
            begin
                errors++;
                $display("%0t unexpected verdict: expected none, got done=%0b rec=%0b win=%0d to=%0b",
                         $time, got.done_res, got.recognized, got.winner_index,
                         got.timed_out);
                return;
            end
            want = due.pop_front();
            if (got !== want)
            begin
                errors++;
                $display("%0t verdict mismatch: expected done=%0b rec=%0b win=%0d to=%0b, %s",
                         $time, want.done_res, want.recognized, want.winner_index,
                         want.timed_out,
                         $sformatf("got done=%0b rec=%0b win=%0d to=%0b",
                                   got.done_res, got.recognized, got.winner_index,
                                   got.timed_out));
            end
        endfunction
    endclass

    logic                          clk = 1'b0;
    logic                          rst_n;
    logic                          in_valid;
    logic                          in_stall;
    logic                          start_req;
    logic                          has_frame;
    logic [rvs_pkg::CNT_W-1:0]     certainty;
    logic [rvs_pkg::IDX_W-1:0]     match_index;
    logic                          out_valid;
    logic                          out_stall;
    logic                          done_res;
    logic                          recognized;
    logic [rvs_pkg::IDX_W-1:0]     winner_index;
    logic                          timed_out;
    logic                          cfg_we;
    logic [rvs_pkg::CFG_IDX_W-1:0] cfg_index;
    logic [rvs_pkg::CNT_W-1:0]     cfg_data;

    verdict_board sb = new();
    int           src_idle_pct;
    int           sink_stall_pct;
    int           quiet_cycles;

    recognition_vote_stabilizer_core dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .start_req    (start_req),
        .has_frame    (has_frame),
        .certainty    (certainty),
        .match_index  (match_index),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .done_res     (done_res),
        .recognized   (recognized),
        .winner_index (winner_index),
        .timed_out    (timed_out),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        out_stall <= ($urandom_range(99) < sink_stall_pct);
    end

    // sample at the falling edge, where both sides have settled
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (in_valid && !in_stall)
                sb.note_poll({start_req, has_frame, certainty, match_index});
            if (out_valid && !out_stall)
                sb.check_verdict({done_res, recognized, winner_index, timed_out});
            if ((in_valid && !in_stall) || (out_valid && !out_stall))
                quiet_cycles = 0;
            else
                quiet_cycles++;
        end
    end

    initial
    begin
        quiet_cycles = 0;
        wait (quiet_cycles >= QUIET_LIMIT);
        $display("tb: failure");
        $finish;
    end

    task automatic send_poll(poll_t p);
        while ($urandom_range(99) < src_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid    <= 1'b1;
        start_req   <= p.start_req;
        has_frame   <= p.has_frame;
        certainty   <= p.certainty;
        match_index <= p.match_index;
        do
            @(negedge clk);
        while (in_stall);
        @(posedge clk);
    endtask

    task automatic settle();
        in_valid <= 1'b0;
        while (sb.due.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic put_reg(logic [rvs_pkg::CFG_IDX_W-1:0] idx,
                           logic [rvs_pkg::CNT_W-1:0] data);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        sb.write_reg(idx, data);
    endtask

    task automatic program_regs(logic [rvs_pkg::CNT_W-1:0] cert,
                                logic [rvs_pkg::CNT_W-1:0] vote,
                                logic [rvs_pkg::CNT_W-1:0] count,
                                logic [rvs_pkg::CNT_W-1:0] limit);
        put_reg(rvs_pkg::CFG_CERT_LIMIT, cert);
        put_reg(rvs_pkg::CFG_VOTE_LIMIT, vote);
        put_reg(rvs_pkg::CFG_OBJ_COUNT, count);
        put_reg(rvs_pkg::CFG_STEP_LIMIT, limit);
        cfg_we <= 1'b0;
    endtask

    function automatic poll_t random_poll(logic start, int fav);
        poll_t p;
        int    n;
        int    roll;
        n = sb.used_objects();
        p.start_req = start;
        p.has_frame = ($urandom_range(9) != 0);
        roll = $urandom_range(9);
        if (roll < 2)
            p.certainty = 16'($urandom_range(16'hFFFF));
        else if (roll < 4 && sb.cert_limit != 0)
            p.certainty = 16'($urandom_range(sb.cert_limit - 1));
        else
            p.certainty = 16'($urandom_range(16'hFFFF, sb.cert_limit));
        roll = $urandom_range(9);
        if (roll < 7)
            p.match_index = fav[rvs_pkg::IDX_W-1:0];
        else if (roll < 9 && n > 0)
            p.match_index = 5'($urandom_range(n - 1));
        else
            p.match_index = 5'($urandom_range(31));
        return p;
    endfunction

    task automatic run_sessions(int quota);
        int    counted;
        int    fav;
        int    n;
        logic  start;
        counted = 0;
        fav     = 0;
        while (counted < quota)
        begin
            n = sb.used_objects();
            if (!sb.active)
                start = ($urandom_range(9) != 0);
            else
                start = ($urandom_range(99) < 3);
            if (start)
                fav = (n > 0) ? int'($urandom_range(n - 1)) : 0;
            if (start || sb.active)
                counted++;
            send_poll(random_poll(start, fav));
        end
    endtask

    initial
    begin
        rst_n          = 1'b0;
        in_valid       = 1'b0;
        start_req      = 1'b0;
        has_frame      = 1'b0;
        certainty      = '0;
        match_index    = '0;
        out_stall      = 1'b0;
        cfg_we         = 1'b0;
        cfg_index      = '0;
        cfg_data       = '0;
        src_idle_pct   = 0;
        sink_stall_pct = 0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // register defaults, idle block, then a session with no objects
        send_poll(poll_t'{1'b0, 1'b1, 16'hFFFF, 5'd31});
        send_poll(poll_t'{1'b1, 1'b1, 16'hFFFF, 5'd0});
        settle();
        program_regs(16'd17039, 16'd3, 16'd2, 16'd6);
        send_poll(poll_t'{1'b1, 1'b1, 16'hFFFF, 5'd0});
        send_poll(poll_t'{1'b0, 1'b1, 16'd17039, 5'd0});
        send_poll(poll_t'{1'b0, 1'b1, 16'hFFFF, 5'd0});
        send_poll(poll_t'{1'b1, 1'b1, 16'd17038, 5'd1});
        repeat (3) send_poll(poll_t'{1'b0, 1'b1, 16'd0, 5'd31});
        send_poll(poll_t'{1'b1, 1'b1, 16'hFFFF, 5'd2});
        send_poll(poll_t'{1'b0, 1'b1, 16'hFFFF, 5'd31});
        repeat (5) send_poll(poll_t'{1'b0, 1'b0, 16'hFFFF, 5'd1});
        send_poll(poll_t'{1'b1, 1'b1, 16'hFFFF, 5'd1});
        send_poll(poll_t'{1'b1, 1'b1, 16'hFFFF, 5'd0});
        send_poll(poll_t'{1'b0, 1'b1, 16'hFFFF, 5'd0});

        for (int ph = 0; ph < 8; ph++)
        begin
            settle();
            case (ph % 4)
                0: begin src_idle_pct = 0;  sink_stall_pct = 0;  end
                1: begin src_idle_pct = 52; sink_stall_pct = 0;  end
                2: begin src_idle_pct = 0;  sink_stall_pct = 52; end
                default: begin src_idle_pct = 32; sink_stall_pct = 32; end
            endcase
            case (ph)
                0: program_regs(16'd17039, 16'd10, 16'd4, 16'd300);
                1: program_regs(16'd0, 16'd0, 16'd16, 16'd1);
                2: program_regs(16'hFFFF, 16'hFFFF, {11'($urandom), 5'd0}, 16'd0);
                3: program_regs(16'($urandom), 16'($urandom_range(20, 2)),
                                16'($urandom_range(16, 1)), 16'($urandom_range(40, 4)));
                4: program_regs(16'd40000, 16'd5, {11'($urandom), 5'd31}, 16'hFFFF);
                5: program_regs(16'($urandom), 16'($urandom_range(12)),
                                16'($urandom_range(31, 17)), 16'($urandom_range(30, 2)));
                6: program_regs(16'($urandom), 16'($urandom_range(8, 1)),
                                16'd1, 16'($urandom_range(20, 1)));
                default: program_regs(16'($urandom), 16'($urandom_range(15, 2)),
                                      16'($urandom_range(16, 2)), 16'($urandom_range(50, 3)));
            endcase
            run_sessions(110);
        end

        settle();
        if (sb.errors == 0 && sb.due.size() == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
